// File: design/tga_rle_pixel_decoder_top_assert.svh
// Assertion macros for the TGA RLE pixel decoder.
// Each macro expects signals clk and rst_n in the scope where it is used.
`ifndef TGA_RLE_PIXEL_DECODER_TOP_ASSERT_SVH
`define TGA_RLE_PIXEL_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define TRLE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define TRLE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/trle_pkg.sv
// Shared types and constants for the TGA RLE pixel decoder.
// No dependencies; used by trle_core and tga_rle_pixel_decoder_top.
package trle_pkg;

  localparam int unsigned TOTAL_W    = 25;
  localparam logic [TOTAL_W-1:0] MAX_PIXELS = 25'h100_0000;

  // Configuration register indexes
  localparam logic [1:0] CFG_WITH_ALPHA  = 2'd0;
  localparam logic [1:0] CFG_PIXEL_TOTAL = 2'd1;

  // Packet header fields
  localparam int unsigned RUN_FLAG_BIT = 7;
  localparam logic [7:0]  COUNT_MASK   = 8'h7F;

  // Byte position in the stream, one-hot
  typedef enum logic [4:0] {
    PH_HDR = 5'b00001,
    PH_B   = 5'b00010,
    PH_G   = 5'b00100,
    PH_R   = 5'b01000,
    PH_A   = 5'b10000
  } phase_t;

  // One decoded pixel
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] repeat_res;
    logic       image_done;
    logic       overrun;
  } pix_res_t;

endpackage

// File: design/trle_core.sv
// Byte-level decode state for the TGA RLE pixel decoder: packet headers,
// pixel assembly, run clipping and image pixel count. Depends on trle_pkg.
module trle_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             step,
  input  logic [7:0]                       stream_byte,
  input  logic                             with_alpha,
  input  logic [trle_pkg::TOTAL_W-1:0]     eff_total,
  output logic                             res_valid,
  output trle_pkg::pix_res_t               res
);

  trle_pkg::phase_t              phase_r, phase_nxt;
  logic                          is_rep_r, is_rep_nxt;
  logic [7:0]                    left_r, left_nxt;
  logic [7:0]                    blue_r, blue_nxt;
  logic [7:0]                    green_r, green_nxt;
  logic [7:0]                    red_r, red_nxt;
  logic [trle_pkg::TOTAL_W-1:0]  done_r, done_nxt;

  logic                          complete;
  logic [7:0]                    alpha_cur;
  logic [7:0]                    count;
  logic [trle_pkg::TOTAL_W:0]    diff;
  logic [trle_pkg::TOTAL_W-1:0]  remaining;
  logic [trle_pkg::TOTAL_W-1:0]  count_ext;
  logic                          clip;
  logic [7:0]                    left_dec;

  // Byte handling per phase, then result and packet bookkeeping
  always_comb begin
    phase_nxt = phase_r;
    is_rep_nxt = is_rep_r;
    left_nxt = left_r;
    blue_nxt = blue_r;
    green_nxt = green_r;
    red_nxt = red_r;
    complete = 1'b0;
    alpha_cur = 8'd0;
    unique case (phase_r)
      trle_pkg::PH_HDR: begin
        is_rep_nxt = stream_byte[trle_pkg::RUN_FLAG_BIT];
        left_nxt = (stream_byte & trle_pkg::COUNT_MASK) + 8'd1;
        phase_nxt = trle_pkg::PH_B;
      end
      trle_pkg::PH_B: begin
        blue_nxt = stream_byte;
        phase_nxt = trle_pkg::PH_G;
      end
      trle_pkg::PH_G: begin
        green_nxt = stream_byte;
        phase_nxt = trle_pkg::PH_R;
      end
      trle_pkg::PH_R: begin
        red_nxt = stream_byte;
        if (with_alpha) begin
          phase_nxt = trle_pkg::PH_A;
        end else begin
          complete = 1'b1;
        end
      end
      trle_pkg::PH_A: begin
        alpha_cur = with_alpha ? stream_byte : 8'd0;
        complete = 1'b1;
      end
      default: begin
        phase_nxt = trle_pkg::PH_HDR;
      end
    endcase

    // Result and packet bookkeeping on a completed pixel
    res.red = red_nxt;
    res.green = green_r;
    res.blue = blue_r;
    res.alpha = alpha_cur;
    res.repeat_res = count;
    res.image_done = 1'b0;
    res.overrun = 1'b0;
    res_valid = complete;
    done_nxt = done_r;
    if (complete) begin
      if (clip) begin
        res.repeat_res = remaining[7:0];
        res.image_done = 1'b1;
        res.overrun = (count_ext > remaining);
        done_nxt = '0;
        is_rep_nxt = 1'b0;
        left_nxt = 8'd0;
        phase_nxt = trle_pkg::PH_HDR;
      end else begin
        done_nxt = done_r + count_ext;
        if (is_rep_r || (left_dec == 8'd0)) begin
          left_nxt = is_rep_r ? 8'd0 : left_dec;
          phase_nxt = trle_pkg::PH_HDR;
        end else begin
          left_nxt = left_dec;
          phase_nxt = trle_pkg::PH_B;
        end
      end
    end
  end

  // Run length and remaining image pixels
  always_comb begin
    count = is_rep_r ? left_r : 8'd1;
    if (count == 8'd0) begin
      count = 8'd1;
    end
    diff = {1'b0, eff_total} - {1'b0, done_r};
    if (diff[trle_pkg::TOTAL_W] || (diff == '0)) begin
      remaining = trle_pkg::TOTAL_W'(1);
    end else begin
      remaining = diff[trle_pkg::TOTAL_W-1:0];
    end
    count_ext = trle_pkg::TOTAL_W'(count);
    clip = (count_ext >= remaining);
    left_dec = left_r - 8'd1;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= trle_pkg::PH_HDR;
      is_rep_r <= 1'b0;
      left_r <= 8'd0;
      done_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      is_rep_r <= is_rep_nxt;
      left_r <= left_nxt;
      done_r <= done_nxt;
    end
  end

  // Held color bytes; always written before a pixel completes
  always_ff @(posedge clk) begin
    if (step) begin
      blue_r <= blue_nxt;
      green_r <= green_nxt;
      red_r <= red_nxt;
    end
  end

endmodule

// File: design/tga_rle_pixel_decoder_top.sv
// Top level of the TGA RLE pixel decoder: config registers, result register.
// Depends on trle_pkg, trle_core and tga_rle_pixel_decoder_top_assert.svh.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------------
//  in      | in        | in_valid / in_ready  | in_stream_byte
//  out     | out       | out_valid / out_ready| out_red/green/blue/alpha, out_repeat_res,
//          |           |                      | out_image_done, out_overrun
//  cfg     | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One byte per cycle while the output is not stalled: the decode state and the result register
// both load at the edge that takes a byte, so a completed pixel shows on out_valid the next cycle.
// in_ready is high whenever the result register is empty or being drained,
// so a stalled output holds one pixel and stops the input. cfg_ready is
// always high. Reset (rst_n low, synchronous) sets with_alpha 0, total 1,
// and expects the first packet header of an image.
module tga_rle_pixel_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_stream_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  output logic [7:0]  out_repeat_res,
  output logic        out_image_done,
  output logic        out_overrun,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [24:0] cfg_data
);

`include "tga_rle_pixel_decoder_top_assert.svh"

  logic                          with_alpha_r;
  logic [trle_pkg::TOTAL_W-1:0]  total_r, total_nxt;
  logic                          in_acc;
  logic                          core_valid;
  trle_pkg::pix_res_t            core_res;
  logic                          out_valid_r, out_valid_nxt;
  trle_pkg::pix_res_t            out_res_r;

  assign cfg_ready = 1'b1;
  assign in_ready = !out_valid_r || out_ready;
  assign in_acc = in_valid && in_ready;

  // Pixel total held already clamped to 1..MAX_PIXELS
  always_comb begin
    if (cfg_data == '0) begin
      total_nxt = trle_pkg::TOTAL_W'(1);
    end else if (cfg_data > trle_pkg::MAX_PIXELS) begin
      total_nxt = trle_pkg::MAX_PIXELS;
    end else begin
      total_nxt = cfg_data;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      with_alpha_r <= 1'b0;
      total_r <= trle_pkg::TOTAL_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == trle_pkg::CFG_WITH_ALPHA) begin
        with_alpha_r <= cfg_data[0];
      end else if (cfg_index == trle_pkg::CFG_PIXEL_TOTAL) begin
        total_r <= total_nxt;
      end
    end
  end

  trle_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (in_acc),
    .stream_byte (in_stream_byte),
    .with_alpha  (with_alpha_r),
    .eff_total   (total_r),
    .res_valid   (core_valid),
    .res         (core_res)
  );

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc) begin
      out_valid_nxt = core_valid;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && core_valid) begin
      out_res_r <= core_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_red = out_res_r.red;
  assign out_green = out_res_r.green;
  assign out_blue = out_res_r.blue;
  assign out_alpha = out_res_r.alpha;
  assign out_repeat_res = out_res_r.repeat_res;
  assign out_image_done = out_res_r.image_done;
  assign out_overrun = out_res_r.overrun;

  // Checks
  `TRLE_ASSERT_IMP(a_rep_range, out_valid_r,
    (out_repeat_res != 8'd0) && (out_repeat_res <= 8'd128), "repeat count out of range")
  `TRLE_ASSERT_IMP(a_over_done, out_valid_r && out_overrun,
    out_image_done, "clipped run without image end")
  `TRLE_ASSERT_NXT(a_no_phantom, in_acc && !core_valid && !out_valid_r,
    !out_valid_r, "result appeared for a byte that completes no pixel")

endmodule

// File: test/tga_rle_pixel_decoder_checker.sv
// Checker for the TGA RLE pixel decoder: watches the byte, result and register channels,
// predicts every decoded pixel and compares it with what the block emits.
// Depends on trle_pkg for the phase type, register indexes and result struct.
module tga_rle_pixel_decoder_checker
  import trle_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_stream_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_red,
  input  logic [7:0]  out_green,
  input  logic [7:0]  out_blue,
  input  logic [7:0]  out_alpha,
  input  logic [7:0]  out_repeat_res,
  input  logic        out_image_done,
  input  logic        out_overrun,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [24:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          pixels_seen,
  output int          images_seen,
  output int          clipped_seen
);

  // Shadow of the decode state and the registers
  phase_t             pos;
  logic               is_run;
  logic [7:0]         pkt_left;
  logic [7:0]         hold_b, hold_g, hold_r;
  logic [TOTAL_W-1:0] px_done;
  logic               alpha_en;
  logic [TOTAL_W-1:0] total_reg;

  pix_res_t expected_pixels[$];

  // Image size as the block uses it: zero counts as one, large values saturate
  function automatic logic [TOTAL_W-1:0] clamp_total(input logic [TOTAL_W-1:0] t);
    logic [TOTAL_W-1:0] v;
    v = t;
    if (v == '0) v = TOTAL_W'(1);
    if (v > MAX_PIXELS) v = MAX_PIXELS;
    return v;
  endfunction

  // Advance the shadow state by one stream byte, queue a pixel when one completes
  task automatic decode_byte(input logic [7:0] b);
    pix_res_t           px;
    logic               complete;
    logic [7:0]         a_val;
    logic [7:0]         cnt;
    logic [TOTAL_W-1:0] tot;
    logic [TOTAL_W-1:0] img_left;
    complete = 1'b0;
    a_val    = 8'h00;
    case (pos)
      PH_HDR: begin
        is_run   = b[RUN_FLAG_BIT];
        pkt_left = (b & COUNT_MASK) + 8'd1;
        pos      = PH_B;
      end
      PH_B: begin
        hold_b = b;
        pos    = PH_G;
      end
      PH_G: begin
        hold_g = b;
        pos    = PH_R;
      end
      PH_R: begin
        hold_r = b;
        if (alpha_en) pos = PH_A;
        else complete = 1'b1;
      end
      default: begin
        // fourth byte finishes the pixel even if alpha was switched off meanwhile
        a_val    = alpha_en ? b : 8'h00;
        complete = 1'b1;
      end
    endcase
    if (complete) begin
      cnt = is_run ? pkt_left : 8'd1;
      if (cnt == 8'd0) cnt = 8'd1;
      tot      = clamp_total(total_reg);
      img_left = (tot > px_done) ? (tot - px_done) : TOTAL_W'(1);
      px.red   = hold_r;
      px.green = hold_g;
      px.blue  = hold_b;
      px.alpha = a_val;
      if (cnt >= img_left) begin
        // run reaches the image end: clip, flag, restart at a header
        px.repeat_res = img_left[7:0];
        px.overrun    = (cnt > img_left);
        px.image_done = 1'b1;
        pos      = PH_HDR;
        is_run   = 1'b0;
        pkt_left = 8'd0;
        px_done  = '0;
      end else begin
        px.repeat_res = cnt;
        px.overrun    = 1'b0;
        px.image_done = 1'b0;
        px_done = px_done + cnt;
        if (is_run) begin
          pkt_left = 8'd0;
          pos      = PH_HDR;
        end else begin
          pkt_left = pkt_left - 8'd1;
          pos      = (pkt_left == 8'd0) ? PH_HDR : PH_B;
        end
      end
      expected_pixels.push_back(px);
    end
  endtask

  // Compare one emitted pixel with the oldest prediction
  task automatic check_pixel();
    pix_res_t got;
    pix_res_t want;
    logic     bad;
    got = '{out_red, out_green, out_blue, out_alpha, out_repeat_res,
            out_image_done, out_overrun};
    pixels_seen++;
    if (got.image_done === 1'b1) images_seen++;
    if (got.overrun === 1'b1) clipped_seen++;
    if (expected_pixels.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("unexpected pixel: r=%02h g=%02h b=%02h a=%02h rep=%0d done=%b over=%b",
                 got.red, got.green, got.blue, got.alpha, got.repeat_res,
                 got.image_done, got.overrun);
    end else begin
      want = expected_pixels.pop_front();
      bad  = (got.red !== want.red) || (got.green !== want.green) ||
             (got.blue !== want.blue) || (got.alpha !== want.alpha) ||
             (got.repeat_res !== want.repeat_res) ||
             (got.image_done !== want.image_done) || (got.overrun !== want.overrun);
      if (bad) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("pixel mismatch #%0d", pixels_seen);
          $display("  exp r=%02h g=%02h b=%02h a=%02h rep=%0d done=%b over=%b",
                   want.red, want.green, want.blue, want.alpha, want.repeat_res,
                   want.image_done, want.overrun);
          $display("  got r=%02h g=%02h b=%02h a=%02h rep=%0d done=%b over=%b",
                   got.red, got.green, got.blue, got.alpha, got.repeat_res,
                   got.image_done, got.overrun);
        end
      end
    end
  endtask

  // Sample all channels at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      pos          = PH_HDR;
      is_run       = 1'b0;
      pkt_left     = 8'd0;
      hold_b       = 8'd0;
      hold_g       = 8'd0;
      hold_r       = 8'd0;
      px_done      = '0;
      alpha_en     = 1'b0;
      total_reg    = TOTAL_W'(1);
      fail_count   = 0;
      pixels_seen  = 0;
      images_seen  = 0;
      clipped_seen = 0;
      expected_pixels.delete();
    end else begin
      if (out_valid && out_ready) check_pixel();
      if (in_valid && in_ready) decode_byte(in_stream_byte);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WITH_ALPHA:  alpha_en  = cfg_data[0];
          CFG_PIXEL_TOTAL: total_reg = cfg_data;
          default: ;
        endcase
      end
    end
    pending = expected_pixels.size();
  end

endmodule

// File: test/tb_tga_rle_pixel_decoder_top.sv
// Testbench top for the TGA RLE pixel decoder: clock, reset, byte stream and register
// stimulus, random output stalls and the verdict.
// Depends on trle_pkg, tga_rle_pixel_decoder_top and tga_rle_pixel_decoder_checker.
module tb_tga_rle_pixel_decoder_top;
  import trle_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_BYTES = 416;
  localparam int SETTLE_CYC   = 4;
  localparam int DRAIN_CYC    = 8;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_stream_byte;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_red, out_green, out_blue, out_alpha, out_repeat_res;
  logic        out_image_done;
  logic        out_overrun;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [24:0] cfg_data;

  int fail_count, pending, pixels_seen, images_seen, clipped_seen;
  int bytes_sent;
  int byte_budget;
  int phases_run;
  bit calm_in;
  bit cur_alpha;

  tga_rle_pixel_decoder_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_stream_byte (in_stream_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_alpha      (out_alpha),
    .out_repeat_res (out_repeat_res),
    .out_image_done (out_image_done),
    .out_overrun    (out_overrun),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  tga_rle_pixel_decoder_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_stream_byte (in_stream_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_alpha      (out_alpha),
    .out_repeat_res (out_repeat_res),
    .out_image_done (out_image_done),
    .out_overrun    (out_overrun),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .pending        (pending),
    .pixels_seen    (pixels_seen),
    .images_seen    (images_seen),
    .clipped_seen   (clipped_seen)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  // Gap length: mostly none or short, a few long
  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Pixels per packet: mostly small, sometimes the full 128
  function automatic int pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return $urandom_range(1, 4);
    if (r < 85) return $urandom_range(5, 20);
    if (r < 93) return $urandom_range(21, 127);
    return 128;
  endfunction

  function automatic int eff_total(input int t);
    if (t == 0) return 1;
    if (t > int'(MAX_PIXELS)) return int'(MAX_PIXELS);
    return t;
  endfunction

  // Result side: ready with random stalls and stall-free stretches
  initial begin
    int run_len;
    int gap;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 8);
      out_ready <= 1'b1;
      repeat (run_len) @(negedge clk);
      gap = pick_gap(1'b0);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  // One stream byte; entered and left at a falling edge, valid kept high on exit
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap(calm_in);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_stream_byte <= b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_pixel();
    int n;
    n = cur_alpha ? 4 : 3;
    repeat (n) send_byte(8'($urandom_range(0, 255)));
  endtask

  // Stop the stream and wait until every pixel is out and the block has settled
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [24:0] val);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_WITH_ALPHA) cur_alpha = val[0];
  endtask

  // Well-formed image of random packets, ending where the image fills up,
  // where max_pkts packets have been sent or where the byte budget runs out
  task automatic send_image(input int px_total, input int max_pkts);
    int left;
    int n;
    int k;
    bit run;
    left = px_total;
    k    = 0;
    while (left > 0 && k < max_pkts && bytes_sent < byte_budget) begin
      run = 1'($urandom_range(0, 1));
      n   = pick_count();
      send_byte({run, 7'(n - 1)});
      if (run) begin
        send_pixel();
        left -= n;
      end else begin
        while (n > 0 && left > 0 && bytes_sent < byte_budget) begin
          send_pixel();
          n--;
          left--;
        end
      end
      k++;
    end
  endtask

  // Stimulus
  initial begin
    int tot_val;
    int r;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_stream_byte = 8'h00;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_WITH_ALPHA;
    cfg_data       = '0;
    calm_in        = 1'b0;
    cur_alpha      = 1'b0;
    bytes_sent     = 0;
    byte_budget    = 0;
    phases_run     = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: one-pixel raw image, 3-byte pixels
    send_byte(8'h00);
    send_byte(8'h00); send_byte(8'hFF); send_byte(8'h80);

    // Longest repeat run clipped to a five-pixel image, 4-byte pixels
    write_reg(CFG_WITH_ALPHA, 25'd1);
    write_reg(CFG_PIXEL_TOTAL, 25'd5);
    send_byte(8'hFF);
    send_byte(8'hFF); send_byte(8'h00); send_byte(8'hAA); send_byte(8'h55);

    // Raw packet crossing the image end: the leftover pixels are never sent
    write_reg(CFG_WITH_ALPHA, 25'd0);
    write_reg(CFG_PIXEL_TOTAL, 25'd2);
    send_byte(8'h04);
    send_byte(8'h01); send_byte(8'h02); send_byte(8'h03);
    send_byte(8'hFE); send_byte(8'hFD); send_byte(8'hFC);

    // Alpha switched off between the third and fourth byte of a pixel
    write_reg(CFG_WITH_ALPHA, 25'd1);
    write_reg(CFG_PIXEL_TOTAL, 25'd10);
    send_byte(8'h81);
    send_byte(8'h11); send_byte(8'h22); send_byte(8'h33); send_byte(8'h44);
    send_byte(8'h80);
    send_byte(8'hAA); send_byte(8'hBB); send_byte(8'hCC);
    write_reg(CFG_WITH_ALPHA, 25'd0);
    send_byte(8'hDD);

    // Total of zero, now below the pixels already done
    write_reg(CFG_PIXEL_TOTAL, 25'd0);
    send_byte(8'h85);
    send_byte(8'h7F); send_byte(8'h80); send_byte(8'h01);

    // Total above the maximum
    write_reg(CFG_PIXEL_TOTAL, 25'h1FF_FFFF);
    send_byte(8'h7F);
    send_byte(8'h5A); send_byte(8'hA5); send_byte(8'hC3);

    // Random phases: new settings, then a few images with occasional noise
    r = bytes_sent;
    byte_budget = r + RANDOM_BYTES;
    while (bytes_sent < byte_budget) begin
      case ($urandom_range(0, 19))
        0:       tot_val = 0;
        1:       tot_val = 25'h1FF_FFFF;
        2:       tot_val = int'(MAX_PIXELS);
        3, 4, 5: tot_val = $urandom_range(13, 200);
        default: tot_val = $urandom_range(1, 12);
      endcase
      write_reg(CFG_WITH_ALPHA, 25'($urandom_range(0, 1)));
      write_reg(CFG_PIXEL_TOTAL, 25'(tot_val));
      calm_in = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 3)) send_image(eff_total(tot_val), 12);
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      phases_run++;
    end

    // Drain and verdict
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
    $display("Sent %0d stream bytes over %0d random setting phases plus directed cases.",
             bytes_sent, phases_run);
    $display("Checked %0d pixels, %0d completed images, %0d clipped runs.",
             pixels_seen, images_seen, clipped_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/trle_pkg.sv
design/trle_core.sv
design/tga_rle_pixel_decoder_top.sv
test/tga_rle_pixel_decoder_checker.sv
test/tb_tga_rle_pixel_decoder_top.sv
